@@ sv/quaternion_vector_rotation_macros.svh @@
// ----------------------------------------------------------------------------
// Quaternion vector rotation assertion macros
// Shared forms of the concurrent checks. Each check samples on the rising edge
// of clk and is disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_VECTOR_ROTATION_MACROS_SVH
`define QUATERNION_VECTOR_ROTATION_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QVR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QVR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/qvr_pkg.sv @@
// ----------------------------------------------------------------------------
// Quaternion vector rotation package
// Direction codes and the fixed vector dimension, used by the input channel and the pipeline modules.
// ----------------------------------------------------------------------------
package qvr_pkg;

  // Direction of the rotation carried with every transaction.
  typedef enum logic {
    ACT_BODY_TO_EARTH = 1'b0,
    ACT_EARTH_TO_BODY = 1'b1
  } action_t;

  // Number of vector components and matrix rows.
  localparam int unsigned NUM_AXES = 3;

endpackage

@@ sv/qvr_in_if.sv @@
// ----------------------------------------------------------------------------
// Quaternion vector rotation input channel
// Valid/ready channel carrying the quaternion, the vector and the direction.
// ----------------------------------------------------------------------------
interface qvr_in_if #(
  parameter int VEC_WIDTH      = 16,
  parameter int QUAT_FRAC_BITS = 15
);
  import qvr_pkg::*;

  logic                        valid;
  logic                        ready;
  action_t                     action;
  logic signed [QUAT_FRAC_BITS:0] quat_w;
  logic signed [QUAT_FRAC_BITS:0] quat_x;
  logic signed [QUAT_FRAC_BITS:0] quat_y;
  logic signed [QUAT_FRAC_BITS:0] quat_z;
  logic signed [VEC_WIDTH-1:0] vec_x;
  logic signed [VEC_WIDTH-1:0] vec_y;
  logic signed [VEC_WIDTH-1:0] vec_z;

  modport source (
    output valid, action, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
    input  ready
  );

  modport sink (
    input  valid, action, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
    output ready
  );

endinterface

@@ sv/qvr_out_if.sv @@
// ----------------------------------------------------------------------------
// Quaternion vector rotation output channel
// Valid/ready channel carrying the rotated vector and the saturation flag.
// ----------------------------------------------------------------------------
interface qvr_out_if #(
  parameter int VEC_WIDTH = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [VEC_WIDTH-1:0] out_x;
  logic signed [VEC_WIDTH-1:0] out_y;
  logic signed [VEC_WIDTH-1:0] out_z;
  logic                        clipped;

  modport source (
    output valid, out_x, out_y, out_z, clipped,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_z, clipped,
    output ready
  );

endinterface

@@ sv/qvr_matrix.sv @@
// ----------------------------------------------------------------------------
// Quaternion vector rotation matrix builder
// Two pipeline stages: the quaternion products, then the rotation matrix
// entries, transposed for the earth-to-body direction.
// ----------------------------------------------------------------------------
module qvr_matrix #(
  parameter int VEC_WIDTH      = 16,
  parameter int QUAT_FRAC_BITS = 15,
  localparam int MW            = 2 * QUAT_FRAC_BITS + 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  qvr_pkg::action_t               action,
  input  logic signed [QUAT_FRAC_BITS:0] quat_w,
  input  logic signed [QUAT_FRAC_BITS:0] quat_x,
  input  logic signed [QUAT_FRAC_BITS:0] quat_y,
  input  logic signed [QUAT_FRAC_BITS:0] quat_z,
  input  logic signed [VEC_WIDTH-1:0]    vec_in  [qvr_pkg::NUM_AXES],
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [MW-1:0]           coef    [qvr_pkg::NUM_AXES][qvr_pkg::NUM_AXES],
  output logic signed [VEC_WIDTH-1:0]    vec_out [qvr_pkg::NUM_AXES]
);
  import qvr_pkg::*;

  localparam int PW = 2 * (QUAT_FRAC_BITS + 1);
  localparam logic signed [MW-1:0] ONE = MW'(1) <<< (2 * QUAT_FRAC_BITS);

  // Stage A: the nine quaternion products.
  logic                        a_valid;
  logic                        a_ready;
  action_t                     a_action;
  logic signed [PW-1:0]        a_bb, a_cc, a_dd, a_bc, a_ad, a_bd, a_ac, a_cd, a_ab;
  logic signed [VEC_WIDTH-1:0] a_vec [NUM_AXES];

  // Stage B: the matrix, already in the orientation that the direction needs.
  logic                        b_valid;
  logic                        b_ready;
  logic signed [MW-1:0]        b_coef [NUM_AXES][NUM_AXES];
  logic signed [VEC_WIDTH-1:0] b_vec  [NUM_AXES];

  logic signed [MW-1:0] e_bb, e_cc, e_dd, e_bc, e_ad, e_bd, e_ac, e_cd, e_ab;
  logic signed [MW-1:0] m [NUM_AXES][NUM_AXES];

  assign b_ready  = !b_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  // The scalar part is a, the vector parts b, c and d.
  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_action <= action;
      a_bb     <= PW'(quat_x) * PW'(quat_x);
      a_cc     <= PW'(quat_y) * PW'(quat_y);
      a_dd     <= PW'(quat_z) * PW'(quat_z);
      a_bc     <= PW'(quat_x) * PW'(quat_y);
      a_ad     <= PW'(quat_w) * PW'(quat_z);
      a_bd     <= PW'(quat_x) * PW'(quat_z);
      a_ac     <= PW'(quat_w) * PW'(quat_y);
      a_cd     <= PW'(quat_y) * PW'(quat_z);
      a_ab     <= PW'(quat_w) * PW'(quat_x);
      a_vec    <= vec_in;
    end
  end

  assign e_bb = MW'(a_bb);
  assign e_cc = MW'(a_cc);
  assign e_dd = MW'(a_dd);
  assign e_bc = MW'(a_bc);
  assign e_ad = MW'(a_ad);
  assign e_bd = MW'(a_bd);
  assign e_ac = MW'(a_ac);
  assign e_cd = MW'(a_cd);
  assign e_ab = MW'(a_ab);

  always_comb begin
    m[0][0] = ONE - ((e_cc + e_dd) <<< 1);
    m[0][1] = (e_bc - e_ad) <<< 1;
    m[0][2] = (e_bd + e_ac) <<< 1;
    m[1][0] = (e_bc + e_ad) <<< 1;
    m[1][1] = ONE - ((e_bb + e_dd) <<< 1);
    m[1][2] = (e_cd - e_ab) <<< 1;
    m[2][0] = (e_bd - e_ac) <<< 1;
    m[2][1] = (e_cd + e_ab) <<< 1;
    m[2][2] = ONE - ((e_bb + e_cc) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        for (int j = 0; j < NUM_AXES; j++) begin
          b_coef[i][j] <= (a_action == ACT_EARTH_TO_BODY) ? m[j][i] : m[i][j];
        end
      end
      b_vec <= a_vec;
    end
  end

  assign out_valid = b_valid;
  assign coef      = b_coef;
  assign vec_out   = b_vec;

endmodule

@@ sv/qvr_mac.sv @@
// ----------------------------------------------------------------------------
// Quaternion vector rotation multiply-accumulate
// Three pipeline stages: split-coefficient products, their recombination, and
// the row sums with the rounding offset added.
// ----------------------------------------------------------------------------
module qvr_mac #(
  parameter int VEC_WIDTH      = 16,
  parameter int QUAT_FRAC_BITS = 15,
  localparam int MW            = 2 * QUAT_FRAC_BITS + 4,
  localparam int AW            = MW + VEC_WIDTH + 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [MW-1:0]        coef [qvr_pkg::NUM_AXES][qvr_pkg::NUM_AXES],
  input  logic signed [VEC_WIDTH-1:0] vec  [qvr_pkg::NUM_AXES],
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [AW-1:0]        acc  [qvr_pkg::NUM_AXES]
);
  import qvr_pkg::*;

  // Each coefficient is split into a signed upper part and an unsigned lower
  // part so that no single multiplier is wider than about half the word.
  localparam int H     = MW / 2;
  localparam int HI_W  = MW - H;
  localparam int LO_PW = H + 1 + VEC_WIDTH;
  localparam int HI_PW = HI_W + VEC_WIDTH;
  localparam int TW    = MW + VEC_WIDTH;
  localparam logic signed [AW-1:0] HALF = AW'(1) <<< (2 * QUAT_FRAC_BITS - 1);

  logic                    c_valid, c_ready;
  logic signed [LO_PW-1:0] c_lo [NUM_AXES][NUM_AXES];
  logic signed [HI_PW-1:0] c_hi [NUM_AXES][NUM_AXES];

  logic                    d_valid, d_ready;
  logic signed [TW-1:0]    d_term [NUM_AXES][NUM_AXES];

  logic                    s_valid, s_ready;
  logic signed [AW-1:0]    s_acc [NUM_AXES];

  assign s_ready  = !s_valid || out_ready;
  assign d_ready  = !d_valid || s_ready;
  assign c_ready  = !c_valid || d_ready;
  assign in_ready = c_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      s_valid <= 1'b0;
    end else begin
      if (c_ready) begin
        c_valid <= in_valid;
      end
      if (d_ready) begin
        d_valid <= c_valid;
      end
      if (s_ready) begin
        s_valid <= d_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && in_valid) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        for (int j = 0; j < NUM_AXES; j++) begin
          c_lo[i][j] <= LO_PW'($signed({1'b0, coef[i][j][H-1:0]})) * LO_PW'(vec[j]);
          c_hi[i][j] <= HI_PW'($signed(coef[i][j][MW-1:H])) * HI_PW'(vec[j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready && c_valid) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        for (int j = 0; j < NUM_AXES; j++) begin
          d_term[i][j] <= (TW'(c_hi[i][j]) <<< H) + TW'(c_lo[i][j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && d_valid) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        s_acc[i] <= AW'(d_term[i][0]) + AW'(d_term[i][1]) + AW'(d_term[i][2]) + HALF;
      end
    end
  end

  assign out_valid = s_valid;
  assign acc       = s_acc;

endmodule

@@ sv/qvr_round.sv @@
// ----------------------------------------------------------------------------
// Quaternion vector rotation rounding and saturation
// Output register stage: drops the fraction bits of each row sum, clamps the
// result to the vector width and flags any clamping.
// ----------------------------------------------------------------------------
module qvr_round #(
  parameter int VEC_WIDTH      = 16,
  parameter int QUAT_FRAC_BITS = 15,
  localparam int AW            = 2 * QUAT_FRAC_BITS + 4 + VEC_WIDTH + 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [AW-1:0]        acc     [qvr_pkg::NUM_AXES],
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [VEC_WIDTH-1:0] vec_out [qvr_pkg::NUM_AXES],
  output logic                        clipped
);
  import qvr_pkg::*;

  localparam int FB = 2 * QUAT_FRAC_BITS;
  localparam int RW = AW - FB;
  localparam logic signed [RW-1:0] SAT_MAX = RW'({1'b0, {(VEC_WIDTH - 1){1'b1}}});
  localparam logic signed [RW-1:0] SAT_MIN = ~SAT_MAX;

  logic                        e_valid, e_ready;
  logic signed [VEC_WIDTH-1:0] e_vec [NUM_AXES];
  logic                        e_clip;

  logic signed [RW-1:0]        whole   [NUM_AXES];
  logic signed [VEC_WIDTH-1:0] sat_val [NUM_AXES];
  logic [NUM_AXES-1:0]         sat_hit;

  assign e_ready  = !e_valid || out_ready;
  assign in_ready = e_ready;

  // The offset of one half is already in the sum, so dropping the fraction
  // bits rounds half toward plus infinity.
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      whole[i] = $signed(acc[i][AW-1:FB]);
      if (whole[i] > SAT_MAX) begin
        sat_val[i] = SAT_MAX[VEC_WIDTH-1:0];
        sat_hit[i] = 1'b1;
      end else if (whole[i] < SAT_MIN) begin
        sat_val[i] = SAT_MIN[VEC_WIDTH-1:0];
        sat_hit[i] = 1'b1;
      end else begin
        sat_val[i] = whole[i][VEC_WIDTH-1:0];
        sat_hit[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (e_ready) begin
      e_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (e_ready && in_valid) begin
      e_vec  <= sat_val;
      e_clip <= |sat_hit;
    end
  end

  assign out_valid = e_valid;
  assign vec_out   = e_vec;
  assign clipped   = e_clip;

endmodule

@@ sv/quaternion_vector_rotation.sv @@
// ----------------------------------------------------------------------------
// Quaternion vector rotation
// Rotates one 3D vector per transaction by the attitude quaternion that comes
// with it. Direction 0 applies the rotation matrix of the quaternion (body to
// earth), direction 1 its transpose (earth to body). The quaternion parts are
// signed fixed point with QUAT_FRAC_BITS fraction bits and are used as given,
// without normalization. The matrix and the products are exact; each output
// component is rounded half toward plus infinity to an integer and clamped
// to the signed VEC_WIDTH-bit range, and clipped is set when any of the three
// components was clamped. The block holds no state between transactions. It
// accepts one transaction per clock cycle while the output is not stalled. Two
// stages build the matrix, one multiplies, two add, and the last rounds and
// saturates into the output register. Every stage has its own valid bit and
// advances whenever the stage after it is empty or moving, so a stall on the
// output fills the empty stages before the input stops.
// ----------------------------------------------------------------------------
`include "quaternion_vector_rotation_macros.svh"

module quaternion_vector_rotation #(
  parameter int VEC_WIDTH      = 16,
  parameter int QUAT_FRAC_BITS = 15
) (
  input  logic      clk,
  input  logic      rst,
  qvr_in_if.sink    req,
  qvr_out_if.source rsp
);
  import qvr_pkg::*;

  localparam int MW = 2 * QUAT_FRAC_BITS + 4;
  localparam int AW = MW + VEC_WIDTH + 2;
  localparam logic signed [VEC_WIDTH-1:0] OUT_MAX = {1'b0, {(VEC_WIDTH - 1){1'b1}}};
  localparam logic signed [VEC_WIDTH-1:0] OUT_MIN = ~OUT_MAX;

  logic signed [VEC_WIDTH-1:0] vec_in [NUM_AXES];

  // Matrix builder to multiply-accumulate.
  logic                        mat_valid, mat_ready;
  logic signed [MW-1:0]        mat_coef [NUM_AXES][NUM_AXES];
  logic signed [VEC_WIDTH-1:0] mat_vec  [NUM_AXES];

  // Multiply-accumulate to rounding.
  logic                        mac_valid, mac_ready;
  logic signed [AW-1:0]        mac_acc [NUM_AXES];

  // Rounded result.
  logic signed [VEC_WIDTH-1:0] res_vec [NUM_AXES];

  // At least one output component sits on a bound of the range.
  logic                        res_at_bound;

  assign vec_in[0] = req.vec_x;
  assign vec_in[1] = req.vec_y;
  assign vec_in[2] = req.vec_z;

  qvr_matrix #(
    .VEC_WIDTH      (VEC_WIDTH),
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_matrix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .action    (req.action),
    .quat_w    (req.quat_w),
    .quat_x    (req.quat_x),
    .quat_y    (req.quat_y),
    .quat_z    (req.quat_z),
    .vec_in    (vec_in),
    .out_valid (mat_valid),
    .out_ready (mat_ready),
    .coef      (mat_coef),
    .vec_out   (mat_vec)
  );

  qvr_mac #(
    .VEC_WIDTH      (VEC_WIDTH),
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mat_valid),
    .in_ready  (mat_ready),
    .coef      (mat_coef),
    .vec       (mat_vec),
    .out_valid (mac_valid),
    .out_ready (mac_ready),
    .acc       (mac_acc)
  );

  qvr_round #(
    .VEC_WIDTH      (VEC_WIDTH),
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mac_valid),
    .in_ready  (mac_ready),
    .acc       (mac_acc),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .vec_out   (res_vec),
    .clipped   (rsp.clipped)
  );

  assign rsp.out_x = res_vec[0];
  assign rsp.out_y = res_vec[1];
  assign rsp.out_z = res_vec[2];

  assign res_at_bound = (rsp.out_x == OUT_MAX) || (rsp.out_x == OUT_MIN) ||
                        (rsp.out_y == OUT_MAX) || (rsp.out_y == OUT_MIN) ||
                        (rsp.out_z == OUT_MAX) || (rsp.out_z == OUT_MIN);

  // The pipeline comes out of reset empty.
  `QVR_ASSERT_IMP(a_reset_empty, $fell(rst), !rsp.valid, "result pending right after reset")
  // With the output register empty, every stage can move, so input is open.
  `QVR_ASSERT_IMP(a_open_when_empty, !rsp.valid, req.ready, "input stalled with empty output")
  // A clamped result leaves at least one component on a range bound.
  `QVR_ASSERT_IMP(a_clip_at_bound, rsp.valid && rsp.clipped, res_at_bound, "clip without bound")

endmodule
